### rtl/core/double_ended_queue_assert.svh
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("double_ended_queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("double_ended_queue: next-cycle check failed");

`endif

### rtl/core/deq_pkg.sv
// Package: shared types and constants of the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

    localparam int DEQ_DEPTH   = 1024;
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 3;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_FRONT      = 3'd6,
        CMD_BACK       = 3'd7
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Strobes from the controller to the entry memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    localparam logic [WORD_W-1:0] EMPTY_ANSWER = '1;

endpackage

### rtl/core/deq_ram.sv
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
module deq_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic               i_clk,
    input  deq_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [DW-1:0]      i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [DW-1:0]      o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/deq_ctrl.sv
// Controller: end pointers, count, overflow flag, sequencer and output register.
`timescale 1ns / 1ps
module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [deq_pkg::CMD_W-1:0]  i_cmd,
    input  logic [deq_pkg::WORD_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [deq_pkg::WORD_W-1:0] o_result,
    output logic                       o_overflow,
    output deq_pkg::t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]              o_wr_addr,
    output logic [deq_pkg::WORD_W-1:0] o_wr_data,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [deq_pkg::WORD_W-1:0] i_rd_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    deq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic            r_ovalid, n_ovalid;
    logic [deq_pkg::WORD_W-1:0] r_odata, n_odata;
    logic            r_oovf, n_oovf;

    deq_pkg::t_cmd   cmd;
    logic            accept, empty, full, go_read, load_now;
    logic [deq_pkg::WORD_W-1:0] now_data;
    logic [AW-1:0]   head_inc, head_dec, tail_inc, tail_dec;

    assign cmd      = deq_pkg::t_cmd'(i_cmd);
    assign empty    = (r_count == '0);
    assign full     = (r_count == FULL_CNT);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign accept   = i_in_valid && o_in_ready;

    // Command decode: pointer updates, memory access, immediate answers.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_ovf     = r_ovf;
        o_mem_ctl = '0;
        o_wr_addr = r_tail;
        o_rd_addr = r_head;
        go_read   = 1'b0;
        load_now  = 1'b0;
        now_data  = deq_pkg::EMPTY_ANSWER;
        if (accept) begin
            case (cmd)
                deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        o_mem_ctl.wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                        if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
                            o_wr_addr = head_dec;
                            n_head    = head_dec;
                        end else begin
                            o_wr_addr = r_tail;
                            n_tail    = tail_inc;
                        end
                    end
                end
                deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
                deq_pkg::CMD_FRONT, deq_pkg::CMD_BACK: begin
                    if (empty) begin
                        load_now = 1'b1;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        go_read = 1'b1;
                        if (cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_FRONT) begin
                            o_rd_addr = r_head;
                        end else begin
                            o_rd_addr = tail_dec;
                        end
                        if (cmd == deq_pkg::CMD_POP_FRONT) begin
                            n_head  = head_inc;
                            n_count = r_count - 1'b1;
                        end
                        if (cmd == deq_pkg::CMD_POP_BACK) begin
                            n_tail  = tail_dec;
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                deq_pkg::CMD_SIZE: begin
                    load_now = 1'b1;
                    now_data = deq_pkg::WORD_W'(r_count);
                end
                deq_pkg::CMD_EMPTY: begin
                    load_now = 1'b1;
                    now_data = {{(deq_pkg::WORD_W-1){1'b0}}, empty};
                end
                default: begin
                    load_now = 1'b0;
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::ST_IDLE: if (go_read) n_state = deq_pkg::ST_READ;
            deq_pkg::ST_READ: n_state = deq_pkg::ST_IDLE;
            default:          n_state = deq_pkg::ST_IDLE;
        endcase
    end

    // State outputs: input ready and the output register load.
    always_comb begin
        o_in_ready = 1'b0;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_odata    = r_odata;
        n_oovf     = r_oovf;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                o_in_ready = !r_ovalid || i_out_ready;
                if (load_now) begin
                    n_ovalid = 1'b1;
                    n_odata  = now_data;
                    n_oovf   = r_ovf;
                end
            end
            deq_pkg::ST_READ: begin
                n_ovalid = 1'b1;
                n_odata  = i_rd_data;
                n_oovf   = r_ovf;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= deq_pkg::ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_oovf  <= n_oovf;
    end

    assign o_wr_data   = i_value;
    assign o_out_valid = r_ovalid;
    assign o_result    = r_odata;
    assign o_overflow  = r_oovf;

endmodule

### rtl/core/double_ended_queue.sv
// Top level: bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps
// Usage
//   Input channel (s_axis): one word per command. tuser carries the command
//   (push to front, push to back, pop from front, pop from back, size, empty,
//   front, back), tdata the value stored by a push. Output channel (m_axis):
//   one word per command that answers (all but the pushes); tdata[31:0] is
//   the popped or peeked value, -1 when the queue is empty, the count or the
//   empty flag, tdata[32] the sticky overflow flag.
//   Pacing: pushes, size, empty and any command on an empty queue leave the
//   input ready for the next command. A pop or peek on a non-empty queue
//   reads the entry memory in the cycle of acceptance, and its registered
//   data reaches the output register by way of the read state, during which
//   input is held. Either way, every result word leaves the output register.
//   A push onto a full queue is dropped and sets the overflow flag until
//   reset. Reset (synchronous, active low) empties the queue and clears the
//   flag; memory contents are not cleared, only occupied entries are read.
//   When the receiver stalls, the result is held in the output register and
//   no further command is taken until it has been drained.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [31:0] push_value
    input  logic [deq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [2:0] command
    input  logic [deq_pkg::CMD_W-1:0]     i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [31:0] result_value, [32] overflow_seen, [39:33] zero
    output logic [deq_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);

    deq_pkg::t_mem_ctl           mem_ctl;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [deq_pkg::WORD_W-1:0]  wr_data, rd_data, result;
    logic                        overflow;

    // Pointer, count and sequencing logic.
    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_deq_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_cmd       (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result),
        .o_overflow  (overflow),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // Ring storage, one entry per slot.
    deq_ram #(
        .AW (AW),
        .DW (deq_pkg::WORD_W)
    ) u_deq_ram (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Pack the result word; pad to whole bytes with zeros.
    assign o_m_axis_tdata = {
        {(deq_pkg::M_TDATA_W - deq_pkg::WORD_W - 1){1'b0}}, overflow, result
    };

endmodule

### rtl/core/deq_checker.sv
// Checker: port-level properties of the double-ended queue, bound to the top.
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"
module deq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [deq_pkg::CMD_W-1:0]     i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [deq_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    logic                        push_acc, quiet_push, out_stall, out_ovf;
    logic [deq_pkg::M_TDATA_W:0] out_word;

    assign push_acc = i_s_axis_tvalid && o_s_axis_tready &&
        (i_s_axis_tuser == deq_pkg::CMD_PUSH_FRONT ||
         i_s_axis_tuser == deq_pkg::CMD_PUSH_BACK);
    assign quiet_push = push_acc && !o_m_axis_tvalid;
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_ovf    = o_m_axis_tvalid && o_m_axis_tdata[deq_pkg::WORD_W];
    assign out_word   = {o_m_axis_tvalid, o_m_axis_tdata};

    // A stalled result word holds.
    `DEQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_stall, $stable(out_word))
    // Overflow, once reported, stays reported on a result word shown straight after it.
    `DEQ_ASSERT_NEXT(a_sticky, i_clk, i_rst_n, out_ovf, !o_m_axis_tvalid || out_ovf)
    // A push taken while no result word is shown makes none.
    `DEQ_ASSERT_NEXT(a_push_quiet, i_clk, i_rst_n, quiet_push, !o_m_axis_tvalid)
    // Ready to take a word straight after reset.
    `DEQ_ASSERT_SAME(a_ready_out_of_reset, i_clk, i_rst_n, $rose(i_rst_n), o_s_axis_tready)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

### tb/double_ended_queue_tb.sv
// Self-checking testbench of the double-ended queue, stream in and stream out.
`timescale 1ns / 1ps
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_WORDS  = 300;
    // No idling on either side once this few command words are left to send.
    localparam int TAIL_WORDS    = 60;
    // Let the output stage settle after the last expected word.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int RING_AW       = $clog2(DEQ_DEPTH);

    // One command word waiting to be sent, or a pause until the output drains.
    typedef struct {
        t_cmd              cmd;
        logic [WORD_W-1:0] value;
        bit                pause;
    } cmd_word_t;

    // One result word as the queue should return it.
    typedef struct {
        logic [WORD_W-1:0] value;
        logic              overflow;
    } answer_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;   // [31:0] push_value
    logic [CMD_W-1:0]     i_s_axis_tuser = '0;   // [2:0] command
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // [31:0] result_value, [32] overflow, [39:33] zero

    double_ended_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    cmd_word_t commands_pending[$];
    answer_t   answers_due[$];

    // Shadow of the queue: ring of words, front index, occupancy, sticky flag.
    logic [WORD_W-1:0]  shadow_ring [DEQ_DEPTH];
    logic [RING_AW-1:0] ring_head = '0;
    logic [RING_AW:0]   ring_fill = '0;
    logic               sticky_overflow = 1'b0;

    // Occupancy as the stimulus generator expects it, used to shape sequences.
    int  gen_fill = 0;
    bit  calm = 1'b0;
    int  mismatch_count = 0;
    int  words_taken = 0;
    int  answers_checked = 0;
    int  dropped_pushes = 0;
    int  empty_reads = 0;
    int  pauses_done = 0;
    int  cycle_count = 0;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Apply one accepted command to the shadow queue and queue up its answer.
    task automatic apply_command(input t_cmd cmd, input logic [WORD_W-1:0] word);
        answer_t            ans;
        logic [RING_AW-1:0] back_slot;
        bit                 is_empty;
        is_empty  = (ring_fill == 0);
        back_slot = RING_AW'((int'(ring_head) + int'(ring_fill) + DEQ_DEPTH - 1) % DEQ_DEPTH);
        ans.value = EMPTY_ANSWER;
        words_taken++;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (ring_fill >= DEQ_DEPTH) begin
                    // drop the word, latch the flag
                    sticky_overflow = 1'b1;
                    dropped_pushes++;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    ring_head = RING_AW'((int'(ring_head) + DEQ_DEPTH - 1) % DEQ_DEPTH);
                    shadow_ring[ring_head] = word;
                    ring_fill++;
                end else begin
                    shadow_ring[RING_AW'((int'(ring_head) + int'(ring_fill)) % DEQ_DEPTH)] = word;
                    ring_fill++;
                end
                return;
            end
            CMD_POP_FRONT: begin
                if (!is_empty) begin
                    ans.value = shadow_ring[ring_head];
                    ring_head = RING_AW'((int'(ring_head) + 1) % DEQ_DEPTH);
                    ring_fill--;
                end
            end
            CMD_POP_BACK: begin
                if (!is_empty) begin
                    ans.value = shadow_ring[back_slot];
                    ring_fill--;
                end
            end
            CMD_SIZE:  ans.value = WORD_W'(ring_fill);
            CMD_EMPTY: ans.value = is_empty ? WORD_W'(1) : '0;
            CMD_FRONT: begin
                if (!is_empty) ans.value = shadow_ring[ring_head];
            end
            default: begin
                if (!is_empty) ans.value = shadow_ring[back_slot];
            end
        endcase
        if (is_empty && cmd inside {CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK}) begin
            empty_reads++;
        end
        ans.overflow = sticky_overflow;
        answers_due = {answers_due, ans};
    endtask

    // Queue a command word and track the occupancy it leads to.
    task automatic add_cmd(input t_cmd cmd, input logic [WORD_W-1:0] word);
        cmd_word_t item;
        item.cmd   = cmd;
        item.value = word;
        item.pause = 1'b0;
        commands_pending = {commands_pending, item};
        if (cmd inside {CMD_PUSH_FRONT, CMD_PUSH_BACK}) begin
            if (gen_fill < DEQ_DEPTH) gen_fill++;
        end else if (cmd inside {CMD_POP_FRONT, CMD_POP_BACK}) begin
            if (gen_fill > 0) gen_fill--;
        end
    endtask

    task automatic add_pause();
        cmd_word_t item;
        item.cmd   = CMD_SIZE;
        item.value = '0;
        item.pause = 1'b1;
        commands_pending = {commands_pending, item};
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic t_cmd push_end();
        return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    endfunction

    function automatic t_cmd pop_end();
        return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    function automatic t_cmd query_cmd();
        case ($urandom_range(0, 3))
            0:       return CMD_SIZE;
            1:       return CMD_EMPTY;
            2:       return CMD_FRONT;
            default: return CMD_BACK;
        endcase
    endfunction

    // Mixed traffic that lets the occupancy wander, with the odd run that
    // drains the queue and reads past its empty end.
    task automatic add_mixed(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                repeat (gen_fill + $urandom_range(1, 3)) add_cmd(pop_end(), rand_word());
            end else if (pick < 47) begin
                add_cmd(push_end(), rand_word());
            end else if (pick < 72) begin
                add_cmd(pop_end(), rand_word());
            end else begin
                add_cmd(query_cmd(), rand_word());
            end
        end
    endtask

    // Sender: present command words from the pending queue, idling in bursts.
    always @(posedge i_clk) begin : sender
        int  gap_left;
        bit  bursty;
        cmd_word_t item;
        if (i_rst_n) begin
            if (commands_pending.size() <= TAIL_WORDS) calm = 1'b1;
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // hold the word until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (commands_pending.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (commands_pending[0].pause) begin
                // wait for every answer in flight before moving on
                i_s_axis_tvalid <= 1'b0;
                if (answers_due.size() == 0 && !(i_s_axis_tvalid && o_s_axis_tready)) begin
                    commands_pending.delete(0);
                    pauses_done++;
                end
            end else begin
                item = commands_pending[0];
                commands_pending.delete(0);
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= item.cmd;
                i_s_axis_tdata  <= item.value;
                if (!calm) begin
                    if ($urandom_range(0, 47) == 0) bursty = !bursty;
                    if (bursty && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 16);
                end
            end
        end
    end

    // Receiver: stall the result stream in bursts, never in the tail.
    always @(posedge i_clk) begin : receiver
        int stall_left;
        bit bursty;
        if (i_rst_n) begin
            if (!calm && $urandom_range(0, 63) == 0) bursty = !bursty;
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && bursty && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 15);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: check each taken result word against the oldest answer due,
    // then fold any command word taken at this edge into the shadow queue.
    always @(posedge i_clk) begin : monitor
        answer_t due;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (answers_due.size() == 0) begin
                    flag_mismatch($sformatf("result word %h with no answer due", o_m_axis_tdata));
                end else begin
                    due = answers_due[0];
                    answers_due.delete(0);
                    answers_checked++;
                    if (o_m_axis_tdata[WORD_W-1:0] !== due.value) begin
                        flag_mismatch($sformatf("result_value %h, expected %h",
                                                o_m_axis_tdata[WORD_W-1:0], due.value));
                    end
                    if (o_m_axis_tdata[WORD_W] !== due.overflow) begin
                        flag_mismatch($sformatf("overflow_seen %b, expected %b",
                                                o_m_axis_tdata[WORD_W], due.overflow));
                    end
                    if (o_m_axis_tdata[M_TDATA_W-1:WORD_W+1] !== '0) begin
                        flag_mismatch($sformatf("padding bits %b, expected zero",
                                                o_m_axis_tdata[M_TDATA_W-1:WORD_W+1]));
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_command(t_cmd'(i_s_axis_tuser), i_s_axis_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers still due",
                     cycle_count, answers_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        // Directed: reads of an empty queue, extreme words at both ends,
        // head wrapping below zero on the first push to the front.
        add_cmd(CMD_POP_FRONT, rand_word());
        add_cmd(CMD_POP_BACK,  rand_word());
        add_cmd(CMD_FRONT,     rand_word());
        add_cmd(CMD_BACK,      rand_word());
        add_cmd(CMD_SIZE,      rand_word());
        add_cmd(CMD_EMPTY,     rand_word());
        add_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
        add_cmd(CMD_PUSH_BACK,  32'h7FFF_FFFF);
        add_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        add_cmd(CMD_PUSH_BACK,  32'h0000_0000);
        add_cmd(CMD_FRONT,     rand_word());
        add_cmd(CMD_BACK,      rand_word());
        add_cmd(CMD_SIZE,      rand_word());
        add_cmd(CMD_EMPTY,     rand_word());
        add_cmd(CMD_PUSH_BACK,  32'h5555_5555);
        add_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        add_cmd(CMD_POP_BACK,  rand_word());
        add_cmd(CMD_POP_FRONT, rand_word());
        add_cmd(CMD_POP_FRONT, rand_word());
        add_cmd(CMD_POP_BACK,  rand_word());
        add_cmd(CMD_POP_FRONT, rand_word());
        add_cmd(CMD_POP_BACK,  rand_word());
        add_cmd(CMD_POP_FRONT, rand_word());
        add_cmd(CMD_EMPTY,     rand_word());
        add_pause();

        add_mixed(RANDOM_WORDS / 2);
        add_pause();
        add_mixed(RANDOM_WORDS / 2);
        add_pause();

        add_mixed(TAIL_WORDS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (commands_pending.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d command words, %0d result words checked, %0d drained pauses",
                 words_taken, answers_checked, pauses_done);
        $display("including %0d pushes dropped on a full queue and %0d reads of an empty one",
                 dropped_pushes, empty_reads);
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue.sv
rtl/core/deq_checker.sv
tb/double_ended_queue_tb.sv
